### src/i2cee_pkg.sv
// Package with phase codes, status codes and request codes for the EEPROM controller.
package i2cee_pkg;

	typedef enum logic [4:0] {
		PH_IDLE      = 5'd0,
		PH_START     = 5'd1,
		PH_SEND_DEVW = 5'd2,
		PH_ACK_DEVW  = 5'd3,
		PH_SEND_ADDR = 5'd4,
		PH_ACK_ADDR  = 5'd5,
		PH_RSTART    = 5'd6,
		PH_SEND_DEVR = 5'd7,
		PH_ACK_DEVR  = 5'd8,
		PH_SEND_DATA = 5'd9,
		PH_ACK_DATA  = 5'd10,
		PH_RECV      = 5'd11,
		PH_MACK      = 5'd12,
		PH_STOP      = 5'd13,
		PH_WAIT      = 5'd14
	} phase_t;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NACK  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic [0:0] REG_DEVICE_ADDRESS = 1'd0;
	localparam logic [0:0] REG_WRITE_WAIT     = 1'd1;

	localparam int CFG_W = 16;

	// Page size of the memory; a power of two so the page offset is a bit slice.
	localparam int PAGE_BYTES = 8;
	localparam int PAGE_W     = 3;

endpackage

### src/i2c_eeprom_controller.sv
// Top level of the slot-level I2C master for a 24C02-style EEPROM.
//
//  channel | direction | handshake        | contents
//  s_axis  | in        | s_axis_tvalid/tready | one bus slot: request, write byte, SDA sample
//  m_axis  | out       | m_axis_tvalid/tready | line drive and transfer status of that slot
//  cfg     | in        | cfg_we           | device address, page write wait
//
// Each request is one bus slot and produces exactly one result in the cycle after it is taken.
// A request is taken in every cycle in which the result register is empty or
// its result is being taken, so one request per cycle is sustained; the phase
// sequencer and its single register stage set that figure.
// Reset puts the sequencer in idle with both lines released.
// A stall on the output holds the result register and stops input intake.
module i2c_eeprom_controller #(
	parameter int MEM_BYTES  = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// bits from low: cmd[1:0], start_addr[9:2], length[18:10], write_byte[26:19],
	// sda_in[27], zero fill
	input  logic [31:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// bits from low: scl_level[0], sda_level[1], busy_res[2], byte_wanted[3],
	// read_data[11:4], read_valid[12], done_res[13], status[15:14]
	output logic [15:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [i2cee_pkg::CFG_W-1:0] cfg_data
);

	logic [1:0] cmd;
	logic [7:0] start_addr;
	logic [8:0] length;
	logic [7:0] write_byte;
	logic       sda_in;
	assign cmd        = s_axis_tdata[1:0];
	assign start_addr = s_axis_tdata[9:2];
	assign length     = s_axis_tdata[18:10];
	assign write_byte = s_axis_tdata[26:19];
	assign sda_in     = s_axis_tdata[27];

	logic [6:0]  dev_addr_q;
	logic [15:0] wait_ticks_q;

	i2cee_pkg::phase_t phase_q, ph;
	logic [1:0]  slot_q, sl;
	logic [3:0]  bitc_q, bc;
	logic [7:0]  shift_q, sh;
	logic [7:0]  addr_q, ad;
	logic [8:0]  rem_q, rm;
	logic [3:0]  pgl_q, pg;
	logic [15:0] wcnt_q, wc;
	logic        ack_q, ak;
	logic        rd_q, ir;
	logic        scl_q, sda_q, scl_n, sda_n;

	logic       busy, want, rv, done, rel;
	logic [7:0] rdat;
	logic [1:0] st;
	logic       take;

	assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
	assign take = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q   <= 7'd80;
			wait_ticks_q <= 16'd1000;
		end else if (cfg_we) begin
			if (cfg_index == i2cee_pkg::REG_DEVICE_ADDRESS)
				dev_addr_q <= cfg_data[6:0];
			else
				wait_ticks_q <= cfg_data;
		end
	end

	// One slot of the sequencer.
	always_comb begin
		logic [8:0] sum;
		logic [7:0] load;
		logic       sendfin, ackfin, startfin, recvfin, mackfin, stopfin;
		logic [4:0] left, chunk;
		ph = phase_q; sl = slot_q; bc = bitc_q; sh = shift_q; ad = addr_q;
		rm = rem_q; pg = pgl_q; wc = wcnt_q; ak = ack_q; ir = rd_q;
		scl_n = scl_q; sda_n = sda_q;
		busy = 1'b0; want = 1'b0; rv = 1'b0; done = 1'b0; rel = 1'b0;
		rdat = 8'd0; st = i2cee_pkg::ST_OK;
		sendfin = 1'b0; ackfin = 1'b0; startfin = 1'b0; recvfin = 1'b0;
		mackfin = 1'b0; stopfin = 1'b0;
		left = 5'd0; chunk = 5'd0;
		sum = 9'(start_addr) + length;

		if (phase_q == i2cee_pkg::PH_IDLE &&
				(cmd == i2cee_pkg::CMD_READ || cmd == i2cee_pkg::CMD_WRITE)) begin
			if ({1'b0, sum} > 10'(MEM_BYTES) || (sum < length)) begin
				done = 1'b1; st = i2cee_pkg::ST_RANGE;
			end else if (cmd == i2cee_pkg::CMD_WRITE && length == 9'd0) begin
				done = 1'b1;
			end else begin
				ad = start_addr; rm = length; ir = (cmd == i2cee_pkg::CMD_READ);
				ak = 1'b1; sl = 2'd0; bc = 4'd0; pg = 4'd0;
				ph = i2cee_pkg::PH_START;
			end
		end

		unique case (ph)
			i2cee_pkg::PH_SEND_DEVW: load = {dev_addr_q, 1'b0};
			i2cee_pkg::PH_SEND_DEVR: load = {dev_addr_q, 1'b1};
			i2cee_pkg::PH_SEND_ADDR: load = ad;
			default:                 load = write_byte;
		endcase

		if (ph != i2cee_pkg::PH_IDLE) begin
			busy = 1'b1;
			unique case (ph) inside
				i2cee_pkg::PH_START, i2cee_pkg::PH_RSTART: begin
					if (sl == 2'd0) begin
						sda_n = 1'b1; scl_n = 1'b1; sl = 2'd1;
					end else if (sl == 2'd1) begin
						sda_n = 1'b0; sl = 2'd2;
					end else begin
						scl_n = 1'b0; sl = 2'd0; bc = 4'd0; startfin = 1'b1;
					end
				end
				i2cee_pkg::PH_SEND_DEVW, i2cee_pkg::PH_SEND_ADDR, i2cee_pkg::PH_SEND_DEVR,
				i2cee_pkg::PH_SEND_DATA: begin
					if (bc == 4'd0 && sl == 2'd0) sh = load;
					if (bc >= 4'd8) begin
						scl_n = 1'b0; bc = 4'd0; sl = 2'd0; sendfin = 1'b1;
					end else if (sl == 2'd0) begin
						scl_n = 1'b0; sl = 2'd1;
					end else if (sl == 2'd1) begin
						sda_n = sh[7]; sl = 2'd2;
					end else begin
						scl_n = 1'b1; sh = {sh[6:0], 1'b0}; bc = bc + 4'd1; sl = 2'd0;
					end
				end
				i2cee_pkg::PH_ACK_DEVW, i2cee_pkg::PH_ACK_ADDR, i2cee_pkg::PH_ACK_DEVR,
				i2cee_pkg::PH_ACK_DATA: begin
					if (sl == 2'd0) begin
						sda_n = 1'b1; sl = 2'd1;
					end else if (sl == 2'd1) begin
						scl_n = 1'b1; ak = !sda_in; sl = 2'd2;
					end else begin
						scl_n = 1'b0; sl = 2'd0; ackfin = 1'b1;
					end
				end
				i2cee_pkg::PH_RECV: begin
					if (bc >= 4'd8) begin
						scl_n = 1'b0; bc = 4'd0; sl = 2'd0; recvfin = 1'b1;
					end else if (sl == 2'd0) begin
						if (bc == 4'd0) sda_n = 1'b1;
						scl_n = 1'b0; sl = 2'd1;
					end else begin
						scl_n = 1'b1; sh = {sh[6:0], sda_in}; bc = bc + 4'd1; sl = 2'd0;
					end
				end
				i2cee_pkg::PH_MACK: begin
					if (sl == 2'd0) begin
						sda_n = (rm <= 9'd1); sl = 2'd1;
					end else if (sl == 2'd1) begin
						scl_n = 1'b1; sl = 2'd2;
					end else begin
						scl_n = 1'b0; sl = 2'd0; mackfin = 1'b1;
					end
				end
				i2cee_pkg::PH_STOP: begin
					if (sl == 2'd0) begin
						sda_n = 1'b0; scl_n = 1'b1; sl = 2'd1;
					end else begin
						sda_n = 1'b1; sl = 2'd0; stopfin = 1'b1;
					end
				end
				default: ;
			endcase

			unique case (ph) inside
				i2cee_pkg::PH_START:
					if (startfin) ph = i2cee_pkg::PH_SEND_DEVW;
				i2cee_pkg::PH_SEND_DEVW:
					if (sendfin) ph = i2cee_pkg::PH_ACK_DEVW;
				i2cee_pkg::PH_ACK_DEVW:
					if (ackfin) ph = ak ? i2cee_pkg::PH_SEND_ADDR : i2cee_pkg::PH_STOP;
				i2cee_pkg::PH_SEND_ADDR:
					if (sendfin) ph = i2cee_pkg::PH_ACK_ADDR;
				i2cee_pkg::PH_ACK_ADDR:
					if (ackfin) begin
						if (!ak) ph = i2cee_pkg::PH_STOP;
						else if (ir) ph = i2cee_pkg::PH_RSTART;
						else begin
							// Bytes up to the next page boundary.
							left = 5'(i2cee_pkg::PAGE_BYTES) -
								{{(5 - i2cee_pkg::PAGE_W){1'b0}}, ad[i2cee_pkg::PAGE_W-1:0]};
							chunk = (rm < 9'(left)) ? rm[4:0] : left;
							pg = 4'(chunk - 5'd1);
							want = 1'b1; ph = i2cee_pkg::PH_SEND_DATA;
						end
					end
				i2cee_pkg::PH_RSTART:
					if (startfin) ph = i2cee_pkg::PH_SEND_DEVR;
				i2cee_pkg::PH_SEND_DEVR:
					if (sendfin) ph = i2cee_pkg::PH_ACK_DEVR;
				i2cee_pkg::PH_ACK_DEVR:
					if (ackfin)
						ph = (ak && rm != 9'd0) ? i2cee_pkg::PH_RECV : i2cee_pkg::PH_STOP;
				i2cee_pkg::PH_SEND_DATA:
					if (sendfin) ph = i2cee_pkg::PH_ACK_DATA;
				i2cee_pkg::PH_ACK_DATA:
					if (ackfin) begin
						if (!ak) ph = i2cee_pkg::PH_STOP;
						else begin
							ad = ad + 8'd1;
							if (rm != 9'd0) rm = rm - 9'd1;
							if (pg == 4'd0 || rm == 9'd0) ph = i2cee_pkg::PH_STOP;
							else begin
								pg = pg - 4'd1; want = 1'b1;
								ph = i2cee_pkg::PH_SEND_DATA;
							end
						end
					end
				i2cee_pkg::PH_RECV:
					if (recvfin) begin
						rdat = sh; rv = 1'b1; ph = i2cee_pkg::PH_MACK;
					end
				i2cee_pkg::PH_MACK:
					if (mackfin) begin
						rel = 1'b1; ad = ad + 8'd1;
						if (rm != 9'd0) rm = rm - 9'd1;
						ph = (rm != 9'd0) ? i2cee_pkg::PH_RECV : i2cee_pkg::PH_STOP;
					end
				i2cee_pkg::PH_STOP:
					if (stopfin) begin
						if (!ak) begin
							done = 1'b1; st = i2cee_pkg::ST_NACK; ph = i2cee_pkg::PH_IDLE;
						end else if (ir) begin
							done = 1'b1; ph = i2cee_pkg::PH_IDLE;
						end else if (wait_ticks_q == 16'd0) begin
							sl = 2'd0; bc = 4'd0;
							if (rm == 9'd0) begin
								done = 1'b1; ph = i2cee_pkg::PH_IDLE;
							end else ph = i2cee_pkg::PH_START;
						end else begin
							wc = wait_ticks_q; ph = i2cee_pkg::PH_WAIT;
						end
					end
				i2cee_pkg::PH_WAIT: begin
					if (wc != 16'd0) wc = wc - 16'd1;
					if (wc == 16'd0) begin
						sl = 2'd0; bc = 4'd0;
						if (rm == 9'd0) begin
							done = 1'b1; ph = i2cee_pkg::PH_IDLE;
						end else ph = i2cee_pkg::PH_START;
					end
				end
				default: begin
					ph = i2cee_pkg::PH_IDLE; sl = 2'd0; bc = 4'd0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= i2cee_pkg::PH_IDLE;
			slot_q  <= 2'd0; bitc_q <= 4'd0; shift_q <= 8'd0; addr_q <= 8'd0;
			rem_q   <= 9'd0; pgl_q <= 4'd0; wcnt_q <= 16'd0;
			ack_q   <= 1'b1; rd_q <= 1'b0; scl_q <= 1'b1; sda_q <= 1'b1;
			m_axis_tvalid <= 1'b0;
		end else begin
			m_axis_tvalid <= take || (m_axis_tvalid && !m_axis_tready);
			if (take) begin
				phase_q <= ph; slot_q <= sl; bitc_q <= bc; shift_q <= sh; addr_q <= ad;
				rem_q <= rm; pgl_q <= pg; wcnt_q <= wc; ack_q <= ak; rd_q <= ir;
				scl_q <= scl_n; sda_q <= rel ? 1'b1 : sda_n;
			end
		end
	end

	// Result register; holds while the consumer stalls.
	always_ff @(posedge clk) begin
		if (take)
			m_axis_tdata <= {st, done, rv, rdat, want, busy, sda_n, scl_n};
	end

endmodule

### src/i2cee_checker.sv
// Port-level checker for the EEPROM controller, bound to the top level.
module i2cee_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	// Each accepted request shows a result on the next cycle.
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
		else $error("no result after accepted request");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// Status is nonzero only together with done.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[13] |-> m_axis_tdata[15:14] == 2'd0)
		else $error("status without done");

	// Read data is only shown with its valid flag.
	a_rdata: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[12] |-> m_axis_tdata[11:4] == 8'd0)
		else $error("read data without valid");

endmodule

bind i2c_eeprom_controller i2cee_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);

### dv/i2c_eeprom_controller_tb.sv
// Testbench for the slot-level I2C EEPROM controller: slot predictor, directed and random tests.
module i2c_eeprom_controller_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MEM_SIZE  = 256;
	localparam int PAGE_SIZE = 8;

	// One slot result, packed in the same order as m_axis_tdata (status in the top bits).
	typedef struct packed {
		logic [1:0] status;
		logic       done;
		logic       rd_valid;
		logic [7:0] rd_data;
		logic       want;
		logic       busy;
		logic       sda;
		logic       scl;
	} slot_res_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [i2cee_pkg::CFG_W-1:0] cfg_data;

	i2c_eeprom_controller dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Expected slot results, oldest first.
	slot_res_t expected_slots[$];
	int        mismatches;
	int        requests_sent;
	bit        quiet;      // when set, neither side idles
	int        nack_pct;   // chance in percent that the memory leaves an ACK slot high

	// Shadow of the controller: registers and sequencer state.
	logic [6:0]  sh_dev;
	logic [15:0] sh_wait_ticks;
	i2cee_pkg::phase_t sh_phase;
	logic [1:0]  sh_slot;
	logic [3:0]  sh_bits;
	logic [7:0]  sh_shift;
	logic [7:0]  sh_addr;
	logic [8:0]  sh_remain;
	logic [3:0]  sh_page_left;
	logic [15:0] sh_wait;
	logic        sh_ack_ok;
	logic        sh_is_read;
	logic        sh_scl;
	logic        sh_sda;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("*** FAILED ***");
		$finish;
	end

	// Sequencer shadow for the START and repeated START: three slots.
	function automatic bit bus_start();
		if (sh_slot == 2'd0) begin
			sh_sda = 1'b1; sh_scl = 1'b1; sh_slot = 2'd1; return 1'b0;
		end
		if (sh_slot == 2'd1) begin
			sh_sda = 1'b0; sh_slot = 2'd2; return 1'b0;
		end
		sh_scl = 1'b0; sh_slot = 2'd0; sh_bits = 4'd0;
		return 1'b1;
	endfunction

	// Eight bits at three slots each, then one slot to hand over to the ACK.
	function automatic bit bus_send(input logic [7:0] load);
		if (sh_bits == 4'd0 && sh_slot == 2'd0)
			sh_shift = load;
		if (sh_bits >= 4'd8) begin
			sh_scl = 1'b0; sh_bits = 4'd0; sh_slot = 2'd0; return 1'b1;
		end
		if (sh_slot == 2'd0) begin
			sh_scl = 1'b0; sh_slot = 2'd1;
		end else if (sh_slot == 2'd1) begin
			sh_sda = sh_shift[7]; sh_slot = 2'd2;
		end else begin
			sh_scl = 1'b1; sh_shift = sh_shift << 1; sh_bits++; sh_slot = 2'd0;
		end
		return 1'b0;
	endfunction

	function automatic bit bus_ack(input logic sda_in);
		if (sh_slot == 2'd0) begin
			sh_sda = 1'b1; sh_slot = 2'd1; return 1'b0;
		end
		if (sh_slot == 2'd1) begin
			sh_scl = 1'b1; sh_ack_ok = (sda_in == 1'b0); sh_slot = 2'd2; return 1'b0;
		end
		sh_scl = 1'b0; sh_slot = 2'd0;
		return 1'b1;
	endfunction

	function automatic void page_or_done(ref slot_res_t r);
		sh_slot = 2'd0; sh_bits = 4'd0;
		if (sh_remain == 9'd0) begin
			r.done = 1'b1; sh_phase = i2cee_pkg::PH_IDLE;
		end else
			sh_phase = i2cee_pkg::PH_START;
	endfunction

	// Works out the result of one bus slot and advances the shadow state.
	function automatic slot_res_t predict_slot(input logic [1:0] cmd, input logic [7:0] sa,
			input logic [8:0] len, input logic [7:0] wb, input logic sda_in);
		slot_res_t r;
		bit release_sda;
		int room;
		int chunk;
		r = '0;
		release_sda = 1'b0;
		if (sh_phase == i2cee_pkg::PH_IDLE &&
				(cmd == i2cee_pkg::CMD_READ || cmd == i2cee_pkg::CMD_WRITE)) begin
			if (int'(sa) + int'(len) > MEM_SIZE) begin
				r.done = 1'b1; r.status = i2cee_pkg::ST_RANGE;
			end else if (cmd == i2cee_pkg::CMD_WRITE && len == 9'd0) begin
				r.done = 1'b1;
			end else begin
				sh_addr = sa; sh_remain = len; sh_is_read = (cmd == i2cee_pkg::CMD_READ);
				sh_ack_ok = 1'b1; sh_slot = 2'd0; sh_bits = 4'd0; sh_page_left = 4'd0;
				sh_phase = i2cee_pkg::PH_START;
			end
		end
		if (sh_phase != i2cee_pkg::PH_IDLE) begin
			r.busy = 1'b1;
			case (sh_phase)
				i2cee_pkg::PH_START: begin
					if (bus_start()) sh_phase = i2cee_pkg::PH_SEND_DEVW;
				end
				i2cee_pkg::PH_SEND_DEVW: begin
					if (bus_send({sh_dev, 1'b0})) sh_phase = i2cee_pkg::PH_ACK_DEVW;
				end
				i2cee_pkg::PH_ACK_DEVW: begin
					if (bus_ack(sda_in))
						sh_phase = sh_ack_ok ? i2cee_pkg::PH_SEND_ADDR : i2cee_pkg::PH_STOP;
				end
				i2cee_pkg::PH_SEND_ADDR: begin
					if (bus_send(sh_addr)) sh_phase = i2cee_pkg::PH_ACK_ADDR;
				end
				i2cee_pkg::PH_ACK_ADDR: begin
					if (bus_ack(sda_in)) begin
						if (!sh_ack_ok)
							sh_phase = i2cee_pkg::PH_STOP;
						else if (sh_is_read)
							sh_phase = i2cee_pkg::PH_RSTART;
						else begin
							// The first page ends at the next page boundary.
							room = PAGE_SIZE - (sh_addr % PAGE_SIZE);
							chunk = (sh_remain < room) ? sh_remain : room;
							sh_page_left = 4'(chunk - 1);
							r.want = 1'b1; sh_phase = i2cee_pkg::PH_SEND_DATA;
						end
					end
				end
				i2cee_pkg::PH_RSTART: begin
					if (bus_start()) sh_phase = i2cee_pkg::PH_SEND_DEVR;
				end
				i2cee_pkg::PH_SEND_DEVR: begin
					if (bus_send({sh_dev, 1'b1})) sh_phase = i2cee_pkg::PH_ACK_DEVR;
				end
				i2cee_pkg::PH_ACK_DEVR: begin
					if (bus_ack(sda_in))
						sh_phase = (sh_ack_ok && sh_remain != 9'd0) ?
							i2cee_pkg::PH_RECV : i2cee_pkg::PH_STOP;
				end
				i2cee_pkg::PH_SEND_DATA: begin
					if (bus_send(wb)) sh_phase = i2cee_pkg::PH_ACK_DATA;
				end
				i2cee_pkg::PH_ACK_DATA: begin
					if (bus_ack(sda_in)) begin
						if (!sh_ack_ok)
							sh_phase = i2cee_pkg::PH_STOP;
						else begin
							sh_addr++;
							if (sh_remain != 9'd0) sh_remain--;
							if (sh_page_left == 4'd0 || sh_remain == 9'd0)
								sh_phase = i2cee_pkg::PH_STOP;
							else begin
								sh_page_left--; r.want = 1'b1;
								sh_phase = i2cee_pkg::PH_SEND_DATA;
							end
						end
					end
				end
				i2cee_pkg::PH_RECV: begin
					if (sh_bits >= 4'd8) begin
						sh_scl = 1'b0; sh_bits = 4'd0; sh_slot = 2'd0;
						r.rd_data = sh_shift; r.rd_valid = 1'b1;
						sh_phase = i2cee_pkg::PH_MACK;
					end else if (sh_slot == 2'd0) begin
						if (sh_bits == 4'd0) sh_sda = 1'b1;
						sh_scl = 1'b0; sh_slot = 2'd1;
					end else begin
						sh_scl = 1'b1; sh_shift = {sh_shift[6:0], sda_in};
						sh_bits++; sh_slot = 2'd0;
					end
				end
				i2cee_pkg::PH_MACK: begin
					// The master ACKs every byte but the last, which it NACKs.
					if (sh_slot == 2'd0) begin
						sh_sda = (sh_remain <= 9'd1); sh_slot = 2'd1;
					end else if (sh_slot == 2'd1) begin
						sh_scl = 1'b1; sh_slot = 2'd2;
					end else begin
						sh_scl = 1'b0; sh_slot = 2'd0; release_sda = 1'b1;
						sh_addr++;
						if (sh_remain != 9'd0) sh_remain--;
						sh_phase = (sh_remain != 9'd0) ? i2cee_pkg::PH_RECV : i2cee_pkg::PH_STOP;
					end
				end
				i2cee_pkg::PH_STOP: begin
					if (sh_slot == 2'd0) begin
						sh_sda = 1'b0; sh_scl = 1'b1; sh_slot = 2'd1;
					end else begin
						sh_sda = 1'b1; sh_slot = 2'd0;
						if (!sh_ack_ok) begin
							r.done = 1'b1; r.status = i2cee_pkg::ST_NACK;
							sh_phase = i2cee_pkg::PH_IDLE;
						end else if (sh_is_read) begin
							r.done = 1'b1; sh_phase = i2cee_pkg::PH_IDLE;
						end else if (sh_wait_ticks == 16'd0)
							page_or_done(r);
						else begin
							sh_wait = sh_wait_ticks; sh_phase = i2cee_pkg::PH_WAIT;
						end
					end
				end
				i2cee_pkg::PH_WAIT: begin
					if (sh_wait != 16'd0) sh_wait--;
					if (sh_wait == 16'd0) page_or_done(r);
				end
				default: begin
					sh_phase = i2cee_pkg::PH_IDLE; sh_slot = 2'd0; sh_bits = 4'd0;
				end
			endcase
		end
		r.scl = sh_scl;
		r.sda = sh_sda;
		if (release_sda) sh_sda = 1'b1;
		return r;
	endfunction

	// Sends one slot request. The memory side is modeled here: in ACK slots it
	// pulls SDA low unless a NACK is drawn, elsewhere the sampled level is random.
	task automatic send_request(input logic [1:0] cmd, input logic [7:0] sa,
			input logic [8:0] len, input logic [7:0] wb);
		logic sda_in;
		if (sh_phase inside {i2cee_pkg::PH_ACK_DEVW, i2cee_pkg::PH_ACK_ADDR,
				i2cee_pkg::PH_ACK_DEVR, i2cee_pkg::PH_ACK_DATA})
			sda_in = ($urandom_range(99) < nack_pct);
		else
			sda_in = $urandom_range(1);
		if (!quiet && $urandom_range(99) < 35) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0, sda_in, wb, len, sa, cmd};
		do @(posedge clk); while (!s_axis_tready);
		expected_slots.push_back(predict_slot(cmd, sa, len, wb, sda_in));
		requests_sent++;
	endtask

	task automatic tick();
		send_request(i2cee_pkg::CMD_TICK, 8'($urandom), 9'($urandom), 8'($urandom));
	endtask

	// Starts a transfer and clocks it to its end; requests sent meanwhile
	// carry random commands, which the controller must ignore.
	task automatic run_transfer(input logic [1:0] cmd, input logic [7:0] sa,
			input logic [8:0] len);
		send_request(cmd, sa, len, 8'($urandom));
		while (sh_phase != i2cee_pkg::PH_IDLE)
			send_request(2'($urandom), 8'($urandom), 9'($urandom), 8'($urandom));
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_slots.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_register(input logic [0:0] idx,
			input logic [i2cee_pkg::CFG_W-1:0] val);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == i2cee_pkg::REG_DEVICE_ADDRESS)
			sh_dev = val[6:0];
		else
			sh_wait_ticks = val;
	endtask

	// Reset device address, special lengths, range errors, odd command, NACK.
	task automatic test_directed();
		nack_pct = 0;
		run_transfer(i2cee_pkg::CMD_READ, 8'd0, 9'd0);
		run_transfer(i2cee_pkg::CMD_WRITE, 8'd10, 9'd0);
		run_transfer(i2cee_pkg::CMD_READ, 8'd255, 9'd1);
		run_transfer(i2cee_pkg::CMD_READ, 8'd255, 9'd2);
		run_transfer(i2cee_pkg::CMD_WRITE, 8'd0, 9'd257);
		run_transfer(i2cee_pkg::CMD_READ, 8'd1, 9'd256);
		run_transfer(2'd3, 8'd0, 9'd1);
		tick();
		nack_pct = 100;
		run_transfer(i2cee_pkg::CMD_WRITE, 8'd4, 9'd2);
		run_transfer(i2cee_pkg::CMD_READ, 8'd4, 9'd2);
		nack_pct = 0;
	endtask

	// Register extremes: address 0 with no write wait and a page split, address
	// 127 with the longest wait skipped by a NACK, then a short wait of one tick.
	task automatic test_register_extremes();
		write_register(i2cee_pkg::REG_DEVICE_ADDRESS, 16'd0);
		write_register(i2cee_pkg::REG_WRITE_WAIT, 16'd0);
		run_transfer(i2cee_pkg::CMD_WRITE, 8'd5, 9'd4);
		run_transfer(i2cee_pkg::CMD_READ, 8'd2, 9'd1);
		write_register(i2cee_pkg::REG_DEVICE_ADDRESS, 16'd127);
		write_register(i2cee_pkg::REG_WRITE_WAIT, 16'hFFFF);
		quiet = 1'b1;
		nack_pct = 100;
		run_transfer(i2cee_pkg::CMD_WRITE, 8'd255, 9'd1);
		nack_pct = 0;
		run_transfer(i2cee_pkg::CMD_READ, 8'd255, 9'd1);
		quiet = 1'b0;
		write_register(i2cee_pkg::REG_WRITE_WAIT, 16'd1);
		run_transfer(i2cee_pkg::CMD_WRITE, 8'd254, 9'd2);
	endtask

	// Random transfers with random content, some noise and some broken ones.
	task automatic test_random_transfers();
		int first;
		int roll;
		int len;
		int sa;
		first = requests_sent;
		while (requests_sent < 1650) begin
			// Every few hundred requests: let the results drain, then reconfigure.
			if ((requests_sent - first) % 400 < 40 && $urandom_range(9) == 0) begin
				write_register(i2cee_pkg::REG_DEVICE_ADDRESS, 16'($urandom_range(127)));
				write_register(i2cee_pkg::REG_WRITE_WAIT, 16'($urandom_range(20)));
			end
			quiet = (requests_sent - first > 200 && requests_sent - first < 500);
			roll = $urandom_range(99);
			nack_pct = (roll < 60) ? 0 : (roll < 85) ? 3 : 30;
			roll = $urandom_range(99);
			if (roll < 8) begin
				repeat ($urandom_range(1, 5)) tick();
			end else if (roll < 18) begin
				// Out of range: address plus length passes the end of the memory.
				sa = $urandom_range(255);
				len = $urandom_range(511, MEM_SIZE - sa + 1);
				run_transfer($urandom_range(1) ? i2cee_pkg::CMD_READ : i2cee_pkg::CMD_WRITE,
					8'(sa), 9'(len));
			end else begin
				len = ($urandom_range(19) == 0) ? $urandom_range(40) : $urandom_range(12);
				sa = $urandom_range(MEM_SIZE - len);
				if (sa > 255) sa = 255;
				run_transfer($urandom_range(1) ? i2cee_pkg::CMD_READ : i2cee_pkg::CMD_WRITE,
					8'(sa), 9'(len));
			end
		end
		quiet = 1'b0;
	endtask

	// Result checker: compares every accepted result with the oldest expectation.
	always @(posedge clk) begin
		slot_res_t got;
		slot_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (expected_slots.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result %h arrived with nothing expected", $realtime, got);
			end else begin
				want = expected_slots.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: mismatch, expected %h got %h", $realtime, want, got);
				end
			end
		end
	end

	// Result side stalls at random unless a quiet stretch is running.
	always @(posedge clk)
		m_axis_tready <= quiet || ($urandom_range(99) >= 35);

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = i2cee_pkg::REG_DEVICE_ADDRESS;
		cfg_data = '0;
		quiet = 1'b0;
		nack_pct = 0;
		mismatches = 0;
		requests_sent = 0;
		sh_dev = 7'd80; sh_wait_ticks = 16'd1000;
		sh_phase = i2cee_pkg::PH_IDLE; sh_slot = '0; sh_bits = '0; sh_shift = '0;
		sh_addr = '0; sh_remain = '0; sh_page_left = '0; sh_wait = '0; sh_ack_ok = 1'b1;
		sh_is_read = 1'b0; sh_scl = 1'b1; sh_sda = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_register_extremes();
		test_random_transfers();

		drain_results();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_slots.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
